FILE: sv/tdfd_pkg.sv
// Shared types and constants for the tail-delimited float deframer.
// Holds result kind codes and the result record; no dependencies.
`timescale 1ns / 1ps

package tdfd_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 9;
    localparam logic [31:0] TAIL_RESET = 32'h7F80_0000;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_OK       = 2'd1,
        KIND_BADLEN   = 2'd2,
        KIND_OVERLONG = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [WORD_W-1:0]   word;
        logic [COUNT_W-1:0]  word_count;
        logic                last;
    } t_result;

endpackage

FILE: sv/tail_delimited_float_deframer.sv
// Tail-delimited deframer: byte stream in, payload words and frame status out.
// Depends on tdfd_pkg for the result kind codes and the result record.
`timescale 1ns / 1ps

// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+------------------------------------
// in       | in  | i_in_valid / o_in_ready    | i_data_byte[7:0]
// out      | out | o_out_valid / i_out_ready  | o_kind, o_word, o_word_count, o_last
// cfg      | in  | i_cfg_valid / o_cfg_ready  | i_cfg_tail_pattern[31:0]
//
// Each byte beat is processed in the cycle it is accepted; its results (zero, one
// or two) enter a four-entry result queue and appear on the out channel from the
// next cycle on, one beat per ready cycle. A byte is taken every cycle while the
// queue has two free entries, so a stalled consumer back-pressures the input once
// three results are queued. Synchronous active-low reset clears the frame state, the
// queue and restores the tail pattern to 0x7F800000. The cfg port is always ready.

module tail_delimited_float_deframer #(
    parameter int unsigned MAX_PAYLOAD_BYTES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_word,
    output logic [8:0]  o_word_count,
    output logic        o_last,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_tail_pattern
);

    import tdfd_pkg::*;

    // Payload byte counter saturates at MAX_PAYLOAD_BYTES.
    localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD_BYTES);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // ------------------------------------------------------------------
    // Frame state
    // ------------------------------------------------------------------
    logic [31:0]      r_tail;
    logic [31:0]      r_window,  n_window;      // oldest byte in bits 7:0
    logic [2:0]       r_fill,    n_fill;        // valid window bytes, 0..4
    logic [23:0]      r_partial, n_partial;
    logic [1:0]       r_biw,     n_biw;         // bytes held in r_partial
    logic [CNT_W-1:0] r_payload, n_payload;
    logic             r_overlong, n_overlong;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    t_result           r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_qcount, n_qcount;

    logic in_fire;
    logic out_fire;

    // Per-byte results
    logic       word_done;
    logic       tail_hit;
    logic [7:0] leaving;
    t_result    word_res;
    t_result    end_res;
    t_result    push0;
    logic       push_one;
    logic       push_two;
    logic [CNT_W+8:0] cnt_wide_word;
    logic [CNT_W+8:0] cnt_wide_end;
    t_kind      end_kind;
    logic [QCNT_W-1:0] push_n;

    assign o_cfg_ready = 1'b1;
    // Keep room for the worst case of two results per byte.
    assign o_in_ready  = (r_qcount <= QCNT_W'(QDEPTH - 2));
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_fire    = o_out_valid && i_out_ready;

    // ------------------------------------------------------------------
    // Window shift, packing and tail compare
    // ------------------------------------------------------------------
    always_comb begin
        n_window   = r_window;
        n_fill     = r_fill;
        n_partial  = r_partial;
        n_biw      = r_biw;
        n_payload  = r_payload;
        n_overlong = r_overlong;
        word_done  = 1'b0;
        leaving    = r_window[7:0];

        if (r_fill[2]) begin
            // Full window: shift in, the oldest byte leaves as payload.
            n_window = {i_data_byte, r_window[31:8]};
            if (r_payload >= CNT_MAX) begin
                // Drop the byte, keep any partial word as is.
                n_overlong = 1'b1;
            end else begin
                n_payload = r_payload + CNT_W'(1);
                if (r_biw == 2'd3) begin
                    word_done = 1'b1;
                    n_partial = '0;
                    n_biw     = '0;
                end else begin
                    case (r_biw)
                        2'd0:    n_partial = {r_partial[23:8], leaving};
                        2'd1:    n_partial = {r_partial[23:16], leaving, r_partial[7:0]};
                        2'd2:    n_partial = {leaving, r_partial[15:0]};
                        default: n_partial = r_partial;
                    endcase
                    n_biw = r_biw + 2'd1;
                end
            end
        end else begin
            // Still filling: place the byte at the next free lane.
            case (r_fill[1:0])
                2'd0:    n_window = {r_window[31:8], i_data_byte};
                2'd1:    n_window = {r_window[31:16], i_data_byte, r_window[7:0]};
                2'd2:    n_window = {r_window[31:24], i_data_byte, r_window[15:0]};
                default: n_window = {i_data_byte, r_window[23:0]};
            endcase
            n_fill = r_fill + 3'd1;
        end

        tail_hit = n_fill[2] && (n_window == r_tail);

        cnt_wide_word = {9'd0, n_payload} >> 2;
        cnt_wide_end  = cnt_wide_word;

        if (n_overlong) begin
            end_kind = KIND_OVERLONG;
        end else if (n_payload[1:0] != 2'd0) begin
            end_kind = KIND_BADLEN;
        end else begin
            end_kind = KIND_OK;
        end

        word_res.kind       = KIND_DATA;
        word_res.word       = {leaving, r_partial};
        word_res.word_count = cnt_wide_word[8:0];
        word_res.last       = !tail_hit;

        end_res.kind        = end_kind;
        end_res.word        = '0;
        end_res.word_count  = cnt_wide_end[8:0];
        end_res.last        = 1'b1;

        if (tail_hit) begin
            // Frame end: clear window, packer and counters.
            n_window   = '0;
            n_fill     = '0;
            n_partial  = '0;
            n_biw      = '0;
            n_payload  = '0;
            n_overlong = 1'b0;
        end

        if (!in_fire) begin
            n_window   = r_window;
            n_fill     = r_fill;
            n_partial  = r_partial;
            n_biw      = r_biw;
            n_payload  = r_payload;
            n_overlong = r_overlong;
        end
    end

    // Data word goes first when both results come from the same byte.
    assign push_two = in_fire && word_done && tail_hit;
    assign push_one = in_fire && (word_done ^ tail_hit);
    assign push0    = word_done ? word_res : end_res;
    assign push_n   = push_two ? QCNT_W'(2) : (push_one ? QCNT_W'(1) : QCNT_W'(0));

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(push_n);
        n_rd_ptr = out_fire ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_qcount = r_qcount + push_n - (out_fire ? QCNT_W'(1) : QCNT_W'(0));
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail     <= TAIL_RESET;
            r_window   <= '0;
            r_fill     <= '0;
            r_partial  <= '0;
            r_biw      <= '0;
            r_payload  <= '0;
            r_overlong <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_qcount   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_tail <= i_cfg_tail_pattern;
            end
            r_window   <= n_window;
            r_fill     <= n_fill;
            r_partial  <= n_partial;
            r_biw      <= n_biw;
            r_payload  <= n_payload;
            r_overlong <= n_overlong;
            r_wr_ptr   <= n_wr_ptr;
            r_rd_ptr   <= n_rd_ptr;
            r_qcount   <= n_qcount;
        end
    end

    // Queue storage: no reset, entries are only read once written.
    always_ff @(posedge i_clk) begin
        if (push_one || push_two) begin
            r_queue[r_wr_ptr] <= push0;
        end
        if (push_two) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= end_res;
        end
    end

    // ------------------------------------------------------------------
    // Output channel: head of the queue
    // ------------------------------------------------------------------
    assign o_out_valid  = (r_qcount != '0);
    assign o_kind       = r_queue[r_rd_ptr].kind;
    assign o_word       = r_queue[r_rd_ptr].word;
    assign o_word_count = r_queue[r_rd_ptr].word_count;
    assign o_last       = r_queue[r_rd_ptr].last;

endmodule
